/* rtl/fpa_pkg.sv */
// shared types, codes and helpers of the fixed-point alu
`default_nettype none

package fpa_pkg;

  // operation selector carried on the input tuser
  typedef enum logic [3:0] {
    OP_ADD = 4'd0,
    OP_SUB = 4'd1,
    OP_EQ  = 4'd2,
    OP_NE  = 4'd3,
    OP_LT  = 4'd4,
    OP_LE  = 4'd5,
    OP_GT  = 4'd6,
    OP_GE  = 4'd7,
    OP_MUL = 4'd8,
    OP_DIV = 4'd9,
    OP_MOD = 4'd10,
    OP_AND = 4'd11,
    OP_OR  = 4'd12,
    OP_XOR = 4'd13,
    OP_SHL = 4'd14,
    OP_SHR = 4'd15
  } fpa_op_e;

  // result status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_DIV0    = 3'd1;
  localparam logic [2:0] ST_MOD0    = 3'd2;
  localparam logic [2:0] ST_WIDTH   = 3'd3;
  localparam logic [2:0] ST_BITWISE = 3'd4;

  // configuration register indexes
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_SIGNED = 2'd1;
  localparam logic [1:0] REG_FRAC   = 2'd2;

  // width codes
  localparam logic [1:0] WC_8  = 2'd0;
  localparam logic [1:0] WC_16 = 2'd1;
  localparam logic [1:0] WC_32 = 2'd2;
  localparam logic [1:0] WC_64 = 2'd3;

  // divider geometry: dividend up to 95 bits, divisor and quotient 32 bits
  localparam int DIV_BITS   = 96;
  localparam int DIV_STEPS  = 4;
  localparam int DIV_STAGES = DIV_BITS / DIV_STEPS;

  typedef struct packed {
    logic [1:0] width_code;
    logic       is_signed;
    logic [6:0] frac;
  } fpa_cfg_t;

  // everything an item carries down the pipeline
  typedef struct packed {
    fpa_op_e               kind;
    logic [1:0]            width_code;
    logic [2:0]            status;
    logic [63:0]           simple;
    logic                  na;
    logic                  nb;
    logic [6:0]            frac;
    logic [31:0]           ma;
    logic [31:0]           mb;
    logic [63:0]           prod;
    logic [DIV_BITS-1:0]   dvd;
    logic [31:0]           rem;
    logic [31:0]           quo;
  } fpa_ctx_t;

  // mask of the storage width
  function automatic logic [63:0] width_mask(logic [1:0] wc);
    logic [63:0] m;
    unique case (wc)
      WC_8:    m = 64'h0000_0000_0000_00FF;
      WC_16:   m = 64'h0000_0000_0000_FFFF;
      WC_32:   m = 64'h0000_0000_FFFF_FFFF;
      default: m = 64'hFFFF_FFFF_FFFF_FFFF;
    endcase
    return m;
  endfunction

endpackage

`default_nettype wire

/* rtl/fpa_decode.sv */
// operand wrapping, magnitudes, simple operations and error checks
`default_nettype none

module fpa_decode #(
  parameter int MaxWidth = 64
) (
  input  fpa_pkg::fpa_cfg_t cfg_i,
  input  fpa_pkg::fpa_op_e  kind_i,
  input  logic [63:0]       left_i,
  input  logic [63:0]       right_i,
  output fpa_pkg::fpa_ctx_t ctx_o
);
  import fpa_pkg::*;

  logic [63:0] m, a, b, flip, ca, cb, ma64, mb64;
  logic        sa, sb_bit;
  logic [6:0]  wid;
  logic        fneg, fzero, bad_width;

  always_comb begin
    m      = width_mask(cfg_i.width_code);
    a      = left_i & m;
    b      = right_i & m;
    wid    = 7'(8 << cfg_i.width_code);
    fneg   = cfg_i.frac[6];
    fzero  = (cfg_i.frac == 7'd0);
    bad_width = (32'(wid) > 32'(MaxWidth));

    // sign bits of the wrapped operands
    unique case (cfg_i.width_code)
      WC_8:    begin sa = a[7];  sb_bit = b[7];  end
      WC_16:   begin sa = a[15]; sb_bit = b[15]; end
      WC_32:   begin sa = a[31]; sb_bit = b[31]; end
      default: begin sa = a[63]; sb_bit = b[63]; end
    endcase

    // magnitudes
    ma64 = (cfg_i.is_signed && sa) ? 64'd0 - (a | ~m) : a;
    mb64 = (cfg_i.is_signed && sb_bit) ? 64'd0 - (b | ~m) : b;
    flip = cfg_i.is_signed ? (m ^ (m >> 1)) : 64'd0;
    ca   = a ^ flip;
    cb   = b ^ flip;

    ctx_o            = '0;
    ctx_o.kind       = kind_i;
    ctx_o.width_code = cfg_i.width_code;
    ctx_o.frac       = cfg_i.frac;
    ctx_o.na         = cfg_i.is_signed && sa;
    ctx_o.nb         = cfg_i.is_signed && sb_bit;
    ctx_o.ma         = ma64[31:0];
    ctx_o.mb         = mb64[31:0];
    ctx_o.status     = ST_OK;
    ctx_o.simple     = 64'd0;

    // add, sub, compares and bitwise work
    unique case (kind_i)
      OP_ADD: ctx_o.simple = a + b;
      OP_SUB: ctx_o.simple = a - b;
      OP_EQ:  ctx_o.simple = {63'd0, a == b};
      OP_NE:  ctx_o.simple = {63'd0, a != b};
      OP_LT:  ctx_o.simple = {63'd0, ca < cb};
      OP_LE:  ctx_o.simple = {63'd0, ca <= cb};
      OP_GT:  ctx_o.simple = {63'd0, ca > cb};
      OP_GE:  ctx_o.simple = {63'd0, ca >= cb};
      OP_AND: ctx_o.simple = a & b;
      OP_OR:  ctx_o.simple = a | b;
      OP_XOR: ctx_o.simple = a ^ b;
      OP_SHL: ctx_o.simple = (b >= 64'(wid)) ? 64'd0 : a << b[5:0];
      OP_SHR: ctx_o.simple = (b >= 64'(wid)) ? 64'd0 : a >> b[5:0];
      default: ctx_o.simple = 64'd0;
    endcase

    // status, in order of precedence
    priority if (bad_width) begin
      ctx_o.status = ST_WIDTH;
    end else if (kind_i == OP_AND || kind_i == OP_OR || kind_i == OP_XOR ||
                 kind_i == OP_SHL || kind_i == OP_SHR) begin
      if (cfg_i.is_signed || !fzero) ctx_o.status = ST_BITWISE;
    end else if (kind_i == OP_MUL || kind_i == OP_DIV || kind_i == OP_MOD) begin
      if (cfg_i.width_code == WC_64) ctx_o.status = ST_WIDTH;
      else if (kind_i == OP_DIV && mb64 == 64'd0) ctx_o.status = ST_DIV0;
      else if (kind_i == OP_MOD && mb64 == 64'd0) ctx_o.status = ST_MOD0;
    end else begin
      ctx_o.status = ST_OK;
    end

    // dividend pre-shift for divide with a non-negative scale
    if (kind_i == OP_DIV && !fneg) begin
      ctx_o.dvd = DIV_BITS'(ma64[31:0]) << cfg_i.frac[5:0];
    end else begin
      ctx_o.dvd = DIV_BITS'(ma64[31:0]);
    end
  end

endmodule

`default_nettype wire

/* rtl/fpa_div_stage.sv */
// one registered slice of the restoring divider
`default_nettype none

module fpa_div_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  fpa_pkg::fpa_ctx_t ctx_i,
  output logic              valid_o,
  output fpa_pkg::fpa_ctx_t ctx_o
);
  import fpa_pkg::*;

  fpa_ctx_t    ctx_d, ctx_q;
  logic        valid_q;
  logic [32:0] trial;
  logic        ge;

  // a few shift-compare-subtract steps
  always_comb begin
    ctx_d = ctx_i;
    trial = 33'd0;
    ge    = 1'b0;
    for (int i = 0; i < DIV_STEPS; i++) begin
      trial     = {ctx_d.rem, ctx_d.dvd[DIV_BITS-1]};
      ctx_d.dvd = {ctx_d.dvd[DIV_BITS-2:0], 1'b0};
      ge        = (trial >= {1'b0, ctx_d.mb});
      ctx_d.rem = ge ? 32'(trial - {1'b0, ctx_d.mb}) : trial[31:0];
      ctx_d.quo = {ctx_d.quo[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) ctx_q <= ctx_d;
  end

  assign valid_o = valid_q;
  assign ctx_o   = ctx_q;

endmodule

`default_nettype wire

/* rtl/fpa_finish.sv */
// rescaling, sign restore, result select and width wrap
`default_nettype none

module fpa_finish (
  input  fpa_pkg::fpa_ctx_t ctx_i,
  output logic [63:0]       value_o,
  output logic [2:0]        status_o
);
  import fpa_pkg::*;

  logic [63:0] m, t, v;
  logic [31:0] qq;
  logic [6:0]  s;
  logic        fneg, neg;

  always_comb begin
    m    = width_mask(ctx_i.width_code);
    fneg = ctx_i.frac[6];
    s    = 7'd0 - ctx_i.frac;
    neg  = ctx_i.na ^ ctx_i.nb;
    t    = 64'd0;
    qq   = 32'd0;

    unique case (ctx_i.kind)
      OP_MUL: begin
        if (!fneg) begin
          t = ctx_i.prod >> ctx_i.frac[5:0];
          v = neg ? 64'd0 - t : t;
        end else begin
          t = neg ? 64'd0 - ctx_i.prod : ctx_i.prod;
          v = s[6] ? 64'd0 : t << s[5:0];
        end
      end
      OP_DIV: begin
        if (!fneg) qq = ctx_i.quo;
        else if (s >= 7'd32) qq = 32'd0;
        else qq = ctx_i.quo >> s[4:0];
        v = neg ? 64'd0 - 64'(qq) : 64'(qq);
      end
      OP_MOD: v = ctx_i.na ? 64'd0 - 64'(ctx_i.rem) : 64'(ctx_i.rem);
      default: v = ctx_i.simple;
    endcase

    status_o = ctx_i.status;
    value_o  = (ctx_i.status != ST_OK) ? 64'd0 : (v & m);
  end

endmodule

`default_nettype wire

/* rtl/fixed_point_alu_unit.sv */
// top level of the pipelined fixed-point alu
// Use: configure width_code, is_signed and the fraction length through cfg_we_i,
// cfg_idx_i and cfg_data_i while no beat is in flight. Each input beat
// carries the operation on s_axis_tuser and the two raw operands on
// s_axis_tdata; each gives exactly one output beat with the wrapped
// value on m_axis_tdata and the status on m_axis_tuser.
// Throughput: one beat per cycle unless m_axis_tready stalls. A beat passes the
// decode and multiply stages, the restoring divider of 96 steps done four per
// stage in 24 stages, and the result stage before m_axis_tvalid.
// Every beat takes the same path, so results leave in order.
// Reset clears all valid bits and loads width 32, signed, no fraction.
// A stall on m_axis_tready freezes the whole pipeline: s_axis_tready
// drops, the waiting result holds and nothing is lost or repeated.
`default_nettype none

module fixed_point_alu_unit #(
  parameter int MAX_WIDTH = 64
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [1:0]   cfg_idx_i,
  input  logic [6:0]   cfg_data_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // right_operand in [127:64], left_operand in [63:0]
  input  logic [3:0]   s_axis_tuser,  // kind
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [63:0]  m_axis_tdata,  // value
  output logic [7:0]   m_axis_tuser   // status, zero fill
);
  import fpa_pkg::*;

  fpa_cfg_t    cfg_q;
  logic        en;
  fpa_ctx_t    dec_ctx, ctx_a_q, ctx_b_q, ctx_b_d;
  logic        valid_a_q, valid_b_q;
  logic        div_valid [DIV_STAGES+1];
  fpa_ctx_t    div_ctx   [DIV_STAGES+1];
  logic [63:0] fin_value, value_q;
  logic [2:0]  fin_status, status_q;
  logic        out_valid_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width_code <= WC_32;
      cfg_q.is_signed  <= 1'b1;
      cfg_q.frac       <= 7'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_WIDTH:  cfg_q.width_code <= cfg_data_i[1:0];
        REG_SIGNED: cfg_q.is_signed  <= cfg_data_i[0];
        REG_FRAC:   cfg_q.frac       <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // global advance whenever the output register is free or drained
  assign en            = !out_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  fpa_decode #(
    .MaxWidth (MAX_WIDTH)
  ) u_decode (
    .cfg_i   (cfg_q),
    .kind_i  (fpa_op_e'(s_axis_tuser)),
    .left_i  (s_axis_tdata[63:0]),
    .right_i (s_axis_tdata[127:64]),
    .ctx_o   (dec_ctx)
  );

  // product of the magnitudes
  always_comb begin
    ctx_b_d      = ctx_a_q;
    ctx_b_d.prod = 64'(ctx_a_q.ma) * 64'(ctx_a_q.mb);
  end

  // decode and multiply stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_a_q <= 1'b0;
      valid_b_q <= 1'b0;
    end else if (en) begin
      valid_a_q <= s_axis_tvalid;
      valid_b_q <= valid_a_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ctx_a_q <= dec_ctx;
      ctx_b_q <= ctx_b_d;
    end
  end

  // divider slices
  assign div_valid[0] = valid_b_q;
  assign div_ctx[0]   = ctx_b_q;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    fpa_div_stage u_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (div_valid[g]),
      .ctx_i   (div_ctx[g]),
      .valid_o (div_valid[g+1]),
      .ctx_o   (div_ctx[g+1])
    );
  end

  fpa_finish u_finish (
    .ctx_i    (div_ctx[DIV_STAGES]),
    .value_o  (fin_value),
    .status_o (fin_status)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      value_q  <= fin_value;
      status_q <= fin_status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = value_q;
  assign m_axis_tuser  = {5'd0, status_q};

  // a stalled result holds until taken
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> out_valid_q && $stable(value_q) && $stable(status_q))
    else $error("result changed while stalled");

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && status_q != ST_OK |-> value_q == 64'd0)
    else $error("error result with nonzero value");

  // status stays within its defined codes
  a_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> status_q <= ST_BITWISE)
    else $error("undefined status code");

  // a stall freezes the head of the pipeline too
  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(valid_a_q) && $stable(valid_b_q))
    else $error("pipeline moved during stall");

endmodule

`default_nettype wire
